@@ sv/wfq_pkg.sv @@
// ----------------------------------------------------------------------------
// wfq_pkg
// Shared types, register indexes and constants of the two-class fair queue.
// ----------------------------------------------------------------------------
package wfq_pkg;

    localparam int DEF_QUEUE_DEPTH = 128;
    localparam int DEF_TIME_WIDTH  = 48;

    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_TCP = 8'd6;

    // result status codes
    localparam logic [1:0] ST_ENQUEUED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_DEQUEUED = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // register indexes
    localparam logic [2:0] REG_BYTE_MODE   = 3'd0;
    localparam logic [2:0] REG_FIRST_MAXP  = 3'd1;
    localparam logic [2:0] REG_SECOND_MAXP = 3'd2;
    localparam logic [2:0] REG_FIRST_MAXB  = 3'd3;
    localparam logic [2:0] REG_SECOND_MAXB = 3'd4;
    localparam logic [2:0] REG_CLASS_PORT  = 3'd5;
    localparam logic [2:0] REG_FIRST_W     = 3'd6;
    localparam logic [2:0] REG_SECOND_W    = 3'd7;

    typedef struct packed {
        logic        byte_mode;
        logic [7:0]  first_max_packets;
        logic [7:0]  second_max_packets;
        logic [23:0] first_max_bytes;
        logic [23:0] second_max_bytes;
        logic [15:0] second_class_port;
        logic [15:0] first_weight;
        logic [15:0] second_weight;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic decide;
        logic start_div;
        logic update;
        logic read_heads;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic div_done;
        logic out_busy;
    } sts_t;

endpackage

@@ sv/two_class_weighted_fair_queue_unit.sv @@
// ----------------------------------------------------------------------------
// two_class_weighted_fair_queue_unit
// Two-class weighted fair queue with finish-time scheduling.
// ----------------------------------------------------------------------------
// usage:
// - s_ channel carries one command transaction: s_tuser is the operation
//   (0 enqueue, 1 dequeue), s_tdata the packet descriptor
// - m_ channel returns exactly one result transaction per command: status,
//   class, dequeued tag and size, and the head that would be served next
// - the apb port holds the eight registers at byte addresses 0,4,..,28;
//   write them only while no command is in flight
// - one command at a time: enqueue or dequeue that does real work passes
//   through the decide, serial divide, update, head-read and report
//   steps before its result; the next command is accepted once the
//   sequencer is back in idle after the report
// - a dropped packet or a dequeue of two empty queues skips the divide,
//   update and head-read steps and goes from decide straight to report
// - the result sits in an output register; the next command is taken while
//   it waits, but a stalled receiver holds back the result after that
// - reset clears pointers, counts, byte totals, virtual time and registers
//   to their defaults; queue entries need no clearing
// ----------------------------------------------------------------------------
module two_class_weighted_fair_queue_unit #(
    parameter int QUEUE_DEPTH = wfq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_WIDTH  = wfq_pkg::DEF_TIME_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] ip_protocol, [23:8] destination_port, [39:24] packet_size,
    // [55:40] packet_tag
    input  logic [55:0] s_tdata,
    // [0] operation
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] class_served, [16:1] out_tag, [32:17] out_size, [33] next_valid,
    // [49:34] next_tag, [55:50] zero
    output logic [55:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    wfq_pkg::cfg_t cfg_reg, cfg_next;
    wfq_pkg::cmd_t cmd;
    wfq_pkg::sts_t sts;

    logic        wr_en;
    logic [2:0]  reg_idx;
    logic        r_class;
    logic [15:0] r_tag, r_size, r_ntag;
    logic        r_nv;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                wfq_pkg::REG_BYTE_MODE:   cfg_next.byte_mode          = pwdata[0];
                wfq_pkg::REG_FIRST_MAXP:  cfg_next.first_max_packets  = pwdata[7:0];
                wfq_pkg::REG_SECOND_MAXP: cfg_next.second_max_packets = pwdata[7:0];
                wfq_pkg::REG_FIRST_MAXB:  cfg_next.first_max_bytes    = pwdata[23:0];
                wfq_pkg::REG_SECOND_MAXB: cfg_next.second_max_bytes   = pwdata[23:0];
                wfq_pkg::REG_CLASS_PORT:  cfg_next.second_class_port  = pwdata[15:0];
                wfq_pkg::REG_FIRST_W:     cfg_next.first_weight       = pwdata[15:0];
                default:                  cfg_next.second_weight      = pwdata[15:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.byte_mode          <= 1'b0;
            cfg_reg.first_max_packets  <= 8'd100;
            cfg_reg.second_max_packets <= 8'd100;
            cfg_reg.first_max_bytes    <= 24'd6553500;
            cfg_reg.second_max_bytes   <= 24'd6553500;
            cfg_reg.second_class_port  <= 16'd3000;
            cfg_reg.first_weight       <= 16'd1;
            cfg_reg.second_weight      <= 16'd1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // register reads
    always_comb begin
        case (reg_idx)
            wfq_pkg::REG_BYTE_MODE:   prdata = {31'd0, cfg_reg.byte_mode};
            wfq_pkg::REG_FIRST_MAXP:  prdata = {24'd0, cfg_reg.first_max_packets};
            wfq_pkg::REG_SECOND_MAXP: prdata = {24'd0, cfg_reg.second_max_packets};
            wfq_pkg::REG_FIRST_MAXB:  prdata = {8'd0, cfg_reg.first_max_bytes};
            wfq_pkg::REG_SECOND_MAXB: prdata = {8'd0, cfg_reg.second_max_bytes};
            wfq_pkg::REG_CLASS_PORT:  prdata = {16'd0, cfg_reg.second_class_port};
            wfq_pkg::REG_FIRST_W:     prdata = {16'd0, cfg_reg.first_weight};
            default:                  prdata = {16'd0, cfg_reg.second_weight};
        endcase
    end

    // sequencer
    wfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // queues, times and result register
    wfq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_op          (s_tuser),
        .in_proto       (s_tdata[7:0]),
        .in_port        (s_tdata[23:8]),
        .in_size        (s_tdata[39:24]),
        .in_tag         (s_tdata[55:40]),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_status     (m_tuser),
        .out_class      (r_class),
        .out_tag        (r_tag),
        .out_size       (r_size),
        .out_next_valid (r_nv),
        .out_next_tag   (r_ntag)
    );

    assign m_tdata = {6'd0, r_ntag, r_nv, r_size, r_tag, r_class};

endmodule

@@ sv/wfq_div.sv @@
// ----------------------------------------------------------------------------
// wfq_div
// Restoring serial divider, 16-bit dividend by 17-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module wfq_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [16:0] dvs_reg, dvs_next;
    logic [17:0] trial;
    logic [17:0] diff;

    assign trial = {rem_reg, quo_reg[15]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 5'd16;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = diff[16:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = trial[16:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/wfq_datapath.sv @@
// ----------------------------------------------------------------------------
// wfq_datapath
// Class queues, pointers, finish and virtual times, divider and result register.
// ----------------------------------------------------------------------------
module wfq_datapath #(
    parameter int QUEUE_DEPTH = wfq_pkg::DEF_QUEUE_DEPTH,
    parameter int TIME_WIDTH  = wfq_pkg::DEF_TIME_WIDTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  wfq_pkg::cfg_t     cfg,
    input  logic              in_op,
    input  logic [7:0]        in_proto,
    input  logic [15:0]       in_port,
    input  logic [15:0]       in_size,
    input  logic [15:0]       in_tag,
    input  wfq_pkg::cmd_t     cmd,
    output wfq_pkg::sts_t     sts,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [1:0]        out_status,
    output logic              out_class,
    output logic [15:0]       out_tag,
    output logic [15:0]       out_size,
    output logic              out_next_valid,
    output logic [15:0]       out_next_tag
);

    localparam int IW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = 32 + TIME_WIDTH;
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

    // latched item
    logic        op_reg;
    logic [7:0]  proto_reg;
    logic [15:0] port_reg;
    logic [15:0] size_reg;
    logic [15:0] tag_reg;

    // queue state
    logic [IW-1:0]         head_reg [2];
    logic [IW-1:0]         tail_reg [2];
    logic [CW-1:0]         cnt_reg  [2];
    logic [23:0]           bytes_reg [2];
    logic [TIME_WIDTH-1:0] tailfin_reg [2];
    logic [TIME_WIDTH-1:0] vt_reg;

    // head entries, refreshed after each change
    logic [15:0]           hd_tag_reg  [2];
    logic [15:0]           hd_size_reg [2];
    logic [TIME_WIDTH-1:0] hd_fin_reg  [2];

    logic [EW-1:0] mem0 [QUEUE_DEPTH];
    logic [EW-1:0] mem1 [QUEUE_DEPTH];
    logic [EW-1:0] rd0_q, rd1_q;

    // decision of the current item
    logic        cls_reg;
    logic [1:0]  status_reg;
    logic [15:0] otag_reg;
    logic [15:0] osize_reg;

    logic        outv_reg;
    logic [1:0]  m_status_reg;
    logic        m_cls_reg;
    logic [15:0] m_tag_reg, m_size_reg, m_ntag_reg;
    logic        m_nv_reg;

    logic        enq_cls;
    logic        ne0, ne1, pick_valid, pick_cls;
    logic [16:0] w0, w1, divisor;
    logic [15:0] dividend;
    logic        drop;
    logic [7:0]  maxp;
    logic [23:0] maxb;
    logic [24:0] byte_sum;
    logic        div_done;
    logic [15:0] quotient;
    logic [TIME_WIDTH-1:0] prev_fin, new_fin, new_vt;
    logic [TIME_WIDTH:0]   fin_sum, vt_sum;
    logic        read_pending_reg;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IW'(1);
    endfunction

    assign w0 = (cfg.first_weight  == 16'd0) ? 17'd1 : {1'b0, cfg.first_weight};
    assign w1 = (cfg.second_weight == 16'd0) ? 17'd1 : {1'b0, cfg.second_weight};

    assign ne0 = cnt_reg[0] != '0;
    assign ne1 = cnt_reg[1] != '0;
    assign pick_valid = ne0 | ne1;
    assign pick_cls = (ne0 && ne1) ? (hd_fin_reg[1] <= hd_fin_reg[0]) : ne1;

    always_comb begin
        enq_cls  = ((proto_reg == wfq_pkg::PROTO_UDP) || (proto_reg == wfq_pkg::PROTO_TCP))
                   && (port_reg == cfg.second_class_port);
        maxp     = enq_cls ? cfg.second_max_packets : cfg.first_max_packets;
        maxb     = enq_cls ? cfg.second_max_bytes : cfg.first_max_bytes;
        byte_sum = {1'b0, bytes_reg[enq_cls]} + {9'd0, size_reg};
        drop     = cnt_reg[enq_cls] >= DEPTH_C;
        if (cfg.byte_mode) begin
            if (byte_sum >= {1'b0, maxb}) drop = 1'b1;
        end else begin
            if (32'(cnt_reg[enq_cls]) >= 32'(maxp)) drop = 1'b1;
        end
        if (op_reg == wfq_pkg::OP_DEQUEUE) begin
            dividend = hd_size_reg[pick_cls];
            divisor  = (ne0 ? w0 : 17'd0) + (ne1 ? w1 : 17'd0);
        end else begin
            dividend = size_reg;
            divisor  = enq_cls ? w1 : w0;
        end
    end

    wfq_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // saturating time sums
    assign prev_fin = (cnt_reg[cls_reg] == '0) ? vt_reg : tailfin_reg[cls_reg];
    assign fin_sum  = {1'b0, prev_fin} + (TIME_WIDTH + 1)'(quotient);
    assign new_fin  = fin_sum[TIME_WIDTH] ? TIME_MAX : fin_sum[TIME_WIDTH-1:0];
    assign vt_sum   = {1'b0, vt_reg} + (TIME_WIDTH + 1)'(quotient);
    assign new_vt   = vt_sum[TIME_WIDTH] ? TIME_MAX : vt_sum[TIME_WIDTH-1:0];

    assign sts.skip     = (op_reg == wfq_pkg::OP_DEQUEUE) ? !pick_valid : drop;
    assign sts.div_done = div_done;
    assign sts.out_busy = outv_reg && !out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg    <= in_op;
            proto_reg <= in_proto;
            port_reg  <= in_port;
            size_reg  <= in_size;
            tag_reg   <= in_tag;
        end
        if (cmd.decide) begin
            if (op_reg == wfq_pkg::OP_DEQUEUE) begin
                cls_reg    <= pick_valid ? pick_cls : 1'b0;
                status_reg <= pick_valid ? wfq_pkg::ST_DEQUEUED : wfq_pkg::ST_EMPTY;
                otag_reg   <= pick_valid ? hd_tag_reg[pick_cls] : 16'd0;
                osize_reg  <= pick_valid ? hd_size_reg[pick_cls] : 16'd0;
            end else begin
                cls_reg    <= enq_cls;
                status_reg <= drop ? wfq_pkg::ST_DROPPED : wfq_pkg::ST_ENQUEUED;
                otag_reg   <= 16'd0;
                osize_reg  <= 16'd0;
            end
        end
    end

    // queue memories
    always_ff @(posedge aclk) begin
        if (cmd.update && op_reg == wfq_pkg::OP_ENQUEUE && !cls_reg)
            mem0[tail_reg[0]] <= {new_fin, size_reg, tag_reg};
        if (cmd.read_heads)
            rd0_q <= mem0[head_reg[0]];
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && op_reg == wfq_pkg::OP_ENQUEUE && cls_reg)
            mem1[tail_reg[1]] <= {new_fin, size_reg, tag_reg};
        if (cmd.read_heads)
            rd1_q <= mem1[head_reg[1]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_pending_reg <= 1'b0;
        end else begin
            read_pending_reg <= cmd.read_heads;
        end
        if (read_pending_reg) begin
            hd_tag_reg[0]  <= rd0_q[15:0];
            hd_size_reg[0] <= rd0_q[31:16];
            hd_fin_reg[0]  <= rd0_q[EW-1:32];
            hd_tag_reg[1]  <= rd1_q[15:0];
            hd_size_reg[1] <= rd1_q[31:16];
            hd_fin_reg[1]  <= rd1_q[EW-1:32];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 2; c++) begin
                head_reg[c]  <= '0;
                tail_reg[c]  <= '0;
                cnt_reg[c]   <= '0;
                bytes_reg[c] <= '0;
            end
            vt_reg <= '0;
        end else if (cmd.update) begin
            if (op_reg == wfq_pkg::OP_ENQUEUE) begin
                tail_reg[cls_reg]  <= next_idx(tail_reg[cls_reg]);
                cnt_reg[cls_reg]   <= cnt_reg[cls_reg] + CW'(1);
                bytes_reg[cls_reg] <= bytes_reg[cls_reg] + {8'd0, size_reg};
            end else begin
                head_reg[cls_reg]  <= next_idx(head_reg[cls_reg]);
                cnt_reg[cls_reg]   <= cnt_reg[cls_reg] - CW'(1);
                bytes_reg[cls_reg] <= bytes_reg[cls_reg] - {8'd0, osize_reg};
                vt_reg             <= new_vt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update && op_reg == wfq_pkg::OP_ENQUEUE)
            tailfin_reg[cls_reg] <= new_fin;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outv_reg <= 1'b0;
        end else if (cmd.load_out) begin
            outv_reg <= 1'b1;
        end else if (out_ready) begin
            outv_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_status_reg <= status_reg;
            m_cls_reg    <= cls_reg;
            m_tag_reg    <= otag_reg;
            m_size_reg   <= osize_reg;
            m_nv_reg     <= pick_valid;
            m_ntag_reg   <= pick_valid ? hd_tag_reg[pick_cls] : 16'd0;
        end
    end

    assign out_valid      = outv_reg;
    assign out_status     = m_status_reg;
    assign out_class      = m_cls_reg;
    assign out_tag        = m_tag_reg;
    assign out_size       = m_size_reg;
    assign out_next_valid = m_nv_reg;
    assign out_next_tag   = m_ntag_reg;

    a_cnt0_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[0] <= DEPTH_C) else $error("class 0 count overflow");

    a_no_drop_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.update && op_reg == wfq_pkg::OP_ENQUEUE) |-> status_reg == wfq_pkg::ST_ENQUEUED)
        else $error("dropped packet written");

    a_cnt_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.update |=> ($stable(cnt_reg[0]) && $stable(cnt_reg[1])))
        else $error("count changed outside update");

endmodule

@@ sv/wfq_ctrl.sv @@
// ----------------------------------------------------------------------------
// wfq_ctrl
// Sequencer: latch, decide, divide, update, head read, report.
// ----------------------------------------------------------------------------
module wfq_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  wfq_pkg::sts_t sts,
    output wfq_pkg::cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_UPDATE = 7'b0001000,
        S_READ   = 7'b0010000,
        S_WAIT   = 7'b0100000,
        S_REPORT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                cmd.decide = 1'b1;
                if (sts.skip) begin
                    state_next = S_REPORT;
                end else begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.div_done) state_next = S_UPDATE;
            end
            S_UPDATE: begin
                cmd.update = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.read_heads = 1'b1;
                state_next     = S_WAIT;
            end
            S_WAIT: begin
                state_next = S_REPORT;
            end
            S_REPORT: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
